/* rtl/assert_macros.svh */
// Assertion helpers, clocked on rising edge, disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* rtl/ctbc_pkg.sv */
package ctbc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CNT_W          = 24;
  localparam int CENT_W         = 12;
  localparam int FRAME_W        = 12;
  localparam int V_W            = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;
  localparam int MIN_MATCHES    = 5;
  localparam int PAIR_PIXELS    = 2;
  localparam int QUEUE_DEPTH    = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_V_MIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V_MAX        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

  localparam logic [V_W-1:0]     V_MIN_RST        = 8'd0;
  localparam logic [V_W-1:0]     V_MAX_RST        = 8'd255;
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd1280;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd720;

  // result kinds
  localparam logic KIND_PIXEL    = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  typedef struct packed {
    logic [V_W-1:0] v_sample;
    logic           frame_end;
  } in_t;

  typedef struct packed {
    logic              kind;
    logic [V_W-1:0]    v_out;
    logic [CENT_W-1:0] centroid_x;
    logic [CENT_W-1:0] centroid_y;
    logic              last;
  } out_t;

  // one queued pixel result
  typedef struct packed {
    logic [V_W-1:0] v_out;
    logic           frame_end;
  } q_entry_t;

endpackage

/* rtl/chroma_threshold_blob_centroid_top.sv */
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   ctbc_pkg::in_t  (v_sample, frame_end)
// out      output     out_valid / out_ready ctbc_pkg::out_t (kind, v_out, centroid, last)
// cfg      input      cfg_we, no wait       cfg_index selects register, cfg_data
//
// Pixel requests stream at one per cycle: front classifies and accumulates,
// a 4-entry queue feeds the back, which registers each result.
// A frame end adds a centroid result once the back has run its two
// restoring dividers (one quotient bit per cycle); pixels keep
// queuing meanwhile, and input stalls when the queue fills or a second
// frame end arrives before the first centroid is handed off.
// Reset (rst_n low, synchronous) clears control state; no clearing pass.
`include "assert_macros.svh"

module chroma_threshold_blob_centroid_top #(
  parameter int COORD_BITS = ctbc_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ctbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctbc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ctbc_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ctbc_pkg::out_t                  out_data
);

  localparam int SUM_W = COORD_BITS + ctbc_pkg::CNT_W;

  logic                 push, pop, q_full, q_empty;
  ctbc_pkg::q_entry_t   push_entry, pop_entry;

  // frame snapshot handed from front to back
  logic                          snap_busy, snap_release;
  logic [SUM_W-1:0]              snap_sum_x, snap_sum_y;
  logic [ctbc_pkg::CNT_W-1:0]    snap_count;
  logic [ctbc_pkg::CENT_W-1:0]   snap_cx_def, snap_cy_def;

  // assertion terms
  logic                          end_accept, centroid_out;

  ctbc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .push         (push),
    .push_entry   (push_entry),
    .q_full       (q_full),
    .snap_release (snap_release),
    .snap_busy    (snap_busy),
    .snap_sum_x   (snap_sum_x),
    .snap_sum_y   (snap_sum_y),
    .snap_count   (snap_count),
    .snap_cx_def  (snap_cx_def),
    .snap_cy_def  (snap_cy_def)
  );

  ctbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_entry),
    .empty     (q_empty)
  );

  ctbc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_entry      (pop_entry),
    .pop          (pop),
    .snap_sum_x   (snap_sum_x),
    .snap_sum_y   (snap_sum_y),
    .snap_count   (snap_count),
    .snap_cx_def  (snap_cx_def),
    .snap_cy_def  (snap_cy_def),
    .snap_release (snap_release),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  assign end_accept   = in_valid && in_ready && in_data.frame_end;
  assign centroid_out = out_valid && (out_data.kind == ctbc_pkg::KIND_CENTROID);

  // accepted frame end holds the snapshot
  `ASSERT_NEXT(a_end_holds_snap, clk, rst_n, end_accept, snap_busy)
  // only a held snapshot is released
  `ASSERT_IMPLIES(a_release_busy, clk, rst_n, snap_release, snap_busy)
  // back never drains an empty queue
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, !q_empty)
  // a centroid result always closes its request
  `ASSERT_IMPLIES(a_centroid_last, clk, rst_n, centroid_out, out_data.last)

endmodule

/* rtl/ctbc_fifo.sv */
module ctbc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ctbc_pkg::q_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output ctbc_pkg::q_entry_t  pop_data,
  output logic                empty
);

  localparam int DEPTH = ctbc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ctbc_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   fill_r;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/ctbc_front.sv */
module ctbc_front #(
  parameter int COORD_BITS = ctbc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ctbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctbc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ctbc_pkg::in_t                         in_data,
  output logic                                  push,
  output ctbc_pkg::q_entry_t                    push_entry,
  input  logic                                  q_full,
  input  logic                                  snap_release,
  output logic                                  snap_busy,
  output logic [COORD_BITS+ctbc_pkg::CNT_W-1:0] snap_sum_x,
  output logic [COORD_BITS+ctbc_pkg::CNT_W-1:0] snap_sum_y,
  output logic [ctbc_pkg::CNT_W-1:0]            snap_count,
  output logic [ctbc_pkg::CENT_W-1:0]           snap_cx_def,
  output logic [ctbc_pkg::CENT_W-1:0]           snap_cy_def
);

  localparam int CNT_W   = ctbc_pkg::CNT_W;
  localparam int SUM_W   = COORD_BITS + CNT_W;
  localparam int FRAME_W = ctbc_pkg::FRAME_W;
  localparam int CENT_W  = ctbc_pkg::CENT_W;
  localparam int CMP_W   = ((COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W) + 1;

  logic [ctbc_pkg::V_W-1:0] v_min_r, v_max_r;
  logic [FRAME_W-1:0]       frame_width_r, frame_height_r;

  logic [COORD_BITS-1:0] column_pos_r, row_pos_r;
  logic [SUM_W-1:0]      sum_x_r, sum_y_r;
  logic [CNT_W-1:0]      count_r;
  logic                  snap_busy_r;

  logic                  match, add, wrap, accept;
  logic [COORD_BITS-1:0] col_odd;
  logic [SUM_W-1:0]      sum_x_upd, sum_y_upd;
  logic [CNT_W-1:0]      count_upd;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_min_r        <= ctbc_pkg::V_MIN_RST;
      v_max_r        <= ctbc_pkg::V_MAX_RST;
      frame_width_r  <= ctbc_pkg::FRAME_WIDTH_RST;
      frame_height_r <= ctbc_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ctbc_pkg::REG_V_MIN:        v_min_r        <= cfg_data[ctbc_pkg::V_W-1:0];
        ctbc_pkg::REG_V_MAX:        v_max_r        <= cfg_data[ctbc_pkg::V_W-1:0];
        ctbc_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FRAME_W-1:0];
        ctbc_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign match     = (in_data.v_sample >= v_min_r) && (in_data.v_sample <= v_max_r);
  assign add       = match && (count_r != {CNT_W{1'b1}});   // count saturates
  assign col_odd   = column_pos_r + 1'b1;
  assign sum_x_upd = sum_x_r + (add ? SUM_W'(col_odd) : '0);
  assign sum_y_upd = sum_y_r + (add ? SUM_W'(row_pos_r) : '0);
  assign count_upd = count_r + CNT_W'(add);
  assign wrap      = (CMP_W'(column_pos_r) + CMP_W'(ctbc_pkg::PAIR_PIXELS))
                     >= CMP_W'(frame_width_r);

  // a frame end waits while the previous frame's snapshot is still in use
  assign in_ready = !q_full && !(in_data.frame_end && snap_busy_r);
  assign accept   = in_valid && in_ready;

  assign push                 = accept;
  assign push_entry.v_out     = match ? '0 : in_data.v_sample;
  assign push_entry.frame_end = in_data.frame_end;
  assign snap_busy            = snap_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r <= '0;
      row_pos_r    <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      count_r      <= '0;
      snap_busy_r  <= 1'b0;
    end else begin
      if (snap_release) begin
        snap_busy_r <= 1'b0;
      end
      if (accept) begin
        if (in_data.frame_end) begin
          column_pos_r <= '0;
          row_pos_r    <= '0;
          sum_x_r      <= '0;
          sum_y_r      <= '0;
          count_r      <= '0;
          snap_busy_r  <= 1'b1;
        end else begin
          sum_x_r <= sum_x_upd;
          sum_y_r <= sum_y_upd;
          count_r <= count_upd;
          if (wrap) begin
            column_pos_r <= '0;
            row_pos_r    <= row_pos_r + 1'b1;
          end else begin
            column_pos_r <= column_pos_r + COORD_BITS'(ctbc_pkg::PAIR_PIXELS);
          end
        end
      end
    end
  end

  // frame snapshot, stable while busy
  always_ff @(posedge clk) begin
    if (accept && in_data.frame_end) begin
      snap_sum_x  <= sum_x_upd;
      snap_sum_y  <= sum_y_upd;
      snap_count  <= count_upd;
      snap_cx_def <= CENT_W'(frame_width_r >> 1);
      snap_cy_def <= CENT_W'(frame_height_r >> 1);
    end
  end

endmodule

/* rtl/ctbc_back.sv */
module ctbc_back #(
  parameter int COORD_BITS = ctbc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  ctbc_pkg::q_entry_t                    q_entry,
  output logic                                  pop,
  input  logic [COORD_BITS+ctbc_pkg::CNT_W-1:0] snap_sum_x,
  input  logic [COORD_BITS+ctbc_pkg::CNT_W-1:0] snap_sum_y,
  input  logic [ctbc_pkg::CNT_W-1:0]            snap_count,
  input  logic [ctbc_pkg::CENT_W-1:0]           snap_cx_def,
  input  logic [ctbc_pkg::CENT_W-1:0]           snap_cy_def,
  output logic                                  snap_release,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ctbc_pkg::out_t                        out_data
);

  localparam int CNT_W  = ctbc_pkg::CNT_W;
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int CW     = ctbc_pkg::CENT_W;
  localparam int STEP_W = $clog2(COORD_BITS);

  localparam logic [1:0] ST_PIX = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_CEN = 2'd2;

  logic [1:0]        state_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  ctbc_pkg::out_t    out_r;

  // restoring dividers: remainder and dividend/quotient shift words
  logic [CNT_W-1:0]      rem_x_r, rem_y_r, rem_x_nxt, rem_y_nxt;
  logic [COORD_BITS-1:0] quo_x_r, quo_y_r, quo_x_nxt, quo_y_nxt;
  logic [CNT_W:0]        tx, ty, dvs;
  logic                  gex, gey, out_free, use_def;

  assign dvs = {1'b0, snap_count};
  assign tx  = {rem_x_r, quo_x_r[COORD_BITS-1]};
  assign ty  = {rem_y_r, quo_y_r[COORD_BITS-1]};
  assign gex = (tx >= dvs);
  assign gey = (ty >= dvs);
  assign rem_x_nxt = gex ? CNT_W'(tx - dvs) : tx[CNT_W-1:0];
  assign rem_y_nxt = gey ? CNT_W'(ty - dvs) : ty[CNT_W-1:0];
  assign quo_x_nxt = {quo_x_r[COORD_BITS-2:0], gex};
  assign quo_y_nxt = {quo_y_r[COORD_BITS-2:0], gey};

  assign use_def      = (snap_count <= CNT_W'(ctbc_pkg::MIN_MATCHES));
  assign out_free     = !out_valid_r || out_ready;
  assign pop          = (state_r == ST_PIX) && !q_empty && out_free;
  assign snap_release = (state_r == ST_CEN) && out_free;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PIX;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_PIX: begin
          if (pop) begin
            out_valid_r <= 1'b1;
            if (q_entry.frame_end) begin
              state_r <= ST_DIV;
              step_r  <= '0;
            end
          end
        end
        ST_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(COORD_BITS - 1)) begin
            state_r <= ST_CEN;
          end
        end
        ST_CEN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_PIX;
          end
        end
        default: state_r <= ST_PIX;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_PIX: begin
        if (pop) begin
          out_r.kind       <= ctbc_pkg::KIND_PIXEL;
          out_r.v_out      <= q_entry.v_out;
          out_r.centroid_x <= '0;
          out_r.centroid_y <= '0;
          out_r.last       <= !q_entry.frame_end;
          // quotient fits COORD_BITS, so the top of the sum is below the count
          rem_x_r <= snap_sum_x[SUM_W-1:COORD_BITS];
          rem_y_r <= snap_sum_y[SUM_W-1:COORD_BITS];
          quo_x_r <= snap_sum_x[COORD_BITS-1:0];
          quo_y_r <= snap_sum_y[COORD_BITS-1:0];
        end
      end
      ST_DIV: begin
        rem_x_r <= rem_x_nxt;
        rem_y_r <= rem_y_nxt;
        quo_x_r <= quo_x_nxt;
        quo_y_r <= quo_y_nxt;
      end
      ST_CEN: begin
        if (out_free) begin
          out_r.kind       <= ctbc_pkg::KIND_CENTROID;
          out_r.v_out      <= '0;
          out_r.centroid_x <= use_def ? snap_cx_def : CW'(quo_x_r);
          out_r.centroid_y <= use_def ? snap_cy_def : CW'(quo_y_r);
          out_r.last       <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* tb/tb_chroma_threshold_blob_centroid_top.sv */
`timescale 1ns / 100ps

module tb_chroma_threshold_blob_centroid_top;
  import ctbc_pkg::*;

  // Frame accumulator predictor plus the queue of results it expects.
  class centroid_scoreboard;
    logic [V_W-1:0]     v_lo, v_hi;
    logic [FRAME_W-1:0] width_px, height_rows;
    logic [11:0]        col, row;
    logic [35:0]        acc_x, acc_y;
    logic [CNT_W-1:0]   hits;
    out_t               expected_q[$];
    int                 errors, centroids, centre_fallbacks, match_total;

    function new();
      v_lo        = V_MIN_RST;
      v_hi        = V_MAX_RST;
      width_px    = FRAME_WIDTH_RST;
      height_rows = FRAME_HEIGHT_RST;
      clear_frame();
    endfunction

    function void clear_frame();
      col   = '0;
      row   = '0;
      acc_x = '0;
      acc_y = '0;
      hits  = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_V_MIN:        v_lo        = data[V_W-1:0];
        REG_V_MAX:        v_hi        = data[V_W-1:0];
        REG_FRAME_WIDTH:  width_px    = data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: height_rows = data[FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(in_t req);
      logic       hit;
      logic [11:0] odd_col;
      out_t       pix, cen;
      hit     = (req.v_sample >= v_lo) && (req.v_sample <= v_hi);
      odd_col = col + 12'd1;
      if (hit && hits != {CNT_W{1'b1}}) begin
        acc_x += odd_col;
        acc_y += row;
        hits++;
      end
      if (hit) match_total++;
      pix       = '0;
      pix.kind  = KIND_PIXEL;
      pix.v_out = hit ? '0 : req.v_sample;
      pix.last  = !req.frame_end;
      expected_q.push_back(pix);
      // pair position steps by two pixels, wrapping to a new row
      if (int'(col) + PAIR_PIXELS >= int'(width_px)) begin
        col = '0;
        row = row + 12'd1;
      end else begin
        col = col + 12'(PAIR_PIXELS);
      end
      if (req.frame_end) begin
        cen      = '0;
        cen.kind = KIND_CENTROID;
        cen.last = 1'b1;
        if (hits > MIN_MATCHES) begin
          cen.centroid_x = CENT_W'(acc_x / hits);
          cen.centroid_y = CENT_W'(acc_y / hits);
        end else begin
          cen.centroid_x = CENT_W'(width_px >> 1);
          cen.centroid_y = CENT_W'(height_rows >> 1);
          centre_fallbacks++;
        end
        centroids++;
        expected_q.push_back(cen);
        clear_frame();
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0b v=%0d cx=%0d cy=%0d last=%0b",
                 $time, got.kind, got.v_out, got.centroid_x, got.centroid_y, got.last);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.kind !== exp_r.kind || got.v_out !== exp_r.v_out ||
          got.centroid_x !== exp_r.centroid_x || got.centroid_y !== exp_r.centroid_y ||
          got.last !== exp_r.last) begin
        errors++;
        $display("%0t: mismatch expected kind=%0b v=%0d cx=%0d cy=%0d last=%0b,",
                 $time, exp_r.kind, exp_r.v_out, exp_r.centroid_x, exp_r.centroid_y,
                 exp_r.last,
                 " got kind=%0b v=%0d cx=%0d cy=%0d last=%0b",
                 got.kind, got.v_out, got.centroid_x, got.centroid_y, got.last);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_V_MIN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;

  centroid_scoreboard sb = new();

  // idle styles: 0 none, 1 occasional gaps, 2 a random gap, possibly none, before every request
  int  send_style = 0;
  int  recv_style = 0;
  bit  hold_req   = 1'b0;
  int  random_sent = 0;
  int  total_sent  = 0;

  chroma_threshold_blob_centroid_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both handshakes are sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic int draw_idle(int style);
    case (style)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // Bias V values toward the window edges and inside the window.
  function automatic logic [V_W-1:0] pick_v();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return sb.v_lo;
      3: return sb.v_hi;
      4: return sb.v_lo - 8'd1;
      5: return sb.v_hi + 8'd1;
      6, 7: return (sb.v_lo <= sb.v_hi) ? 8'($urandom_range(sb.v_lo, sb.v_hi))
                                         : 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one pixel request and hold it until the block takes it.
  // Valid is only lowered when a gap follows, so it never toggles within a step.
  task automatic send_req(logic [V_W-1:0] v, logic fe);
    int gap;
    in_t req;
    gap           = draw_idle(send_style);
    req.v_sample  = v;
    req.frame_end = fe;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    total_sent++;
  endtask

  // Stop offering and wait for every expected result, plus the divider time.
  task automatic settle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (COORD_BITS_DEF + 8) @(posedge clk);
  endtask

  // Writes all four registers back to back; only called while idle.
  task automatic write_regs(logic [V_W-1:0] lo, logic [V_W-1:0] hi,
                            logic [FRAME_W-1:0] w, logic [FRAME_W-1:0] h);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_V_MIN, REG_V_MAX, REG_FRAME_WIDTH, REG_FRAME_HEIGHT};
    val = '{CFG_DATA_W'(lo), CFG_DATA_W'(hi), w, h};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random frames: mostly short, now and then a long one.
  task automatic run_frames(int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        send_req(pick_v(), i == len - 1);
        random_sent++;
      end
      left -= len;
    end
  endtask

  task automatic random_config();
    logic [V_W-1:0]     a, b, lo, hi;
    logic [FRAME_W-1:0] w, h;
    a = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(0, 5))
      0:       begin lo = 8'd0; hi = 8'd255; end
      1:       begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end  // empty unless equal
      2:       begin lo = a; hi = a; end
      default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
    endcase
    case ($urandom_range(0, 7))
      0:       w = 12'd2;
      1:       w = 12'd1;     // each pair forms its own row
      2:       w = 12'd4094;
      3:       w = 12'd3;     // odd width
      default: w = 12'($urandom_range(2, 24));
    endcase
    case ($urandom_range(0, 3))
      0:       h = 12'd1;
      1:       h = 12'd4095;
      default: h = 12'($urandom_range(1, 4095));
    endcase
    write_regs(lo, hi, w, h);
  endtask

  // Result side: random stalls per result, plus one long hold-off on request.
  initial begin
    int stall, held;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(posedge clk);
          held++;
        end
      end
      stall = draw_idle(recv_style);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset configuration (full window, 1280x720):
    // a three-match frame falls back to the centre, a seven-match one divides.
    send_req(8'd0, 1'b0);
    send_req(8'd255, 1'b0);
    send_req(8'h5a, 1'b1);
    for (int i = 0; i < 7; i++) send_req(8'(i * 37), i == 6);
    settle();

    // Empty window (v_min above v_max): nothing matches, centre from the registers.
    write_regs(8'd100, 8'd50, 12'd4, 12'd4095);
    send_req(8'd0, 1'b0);
    send_req(8'd255, 1'b0);
    send_req(8'd100, 1'b0);
    send_req(8'd50, 1'b1);
    settle();

    // Single-value window on an odd width: just past the fallback threshold.
    write_regs(8'd128, 8'd128, 12'd3, 12'd1);
    send_req(8'd127, 1'b0);
    send_req(8'd129, 1'b0);
    for (int i = 0; i < 6; i++) send_req(8'd128, i == 5);
    settle();

    // Widest frame, matches only at the end of a partial first row.
    write_regs(8'd200, 8'd200, 12'd4094, 12'd4095);
    for (int i = 0; i < 60; i++)
      send_req((i >= 54) ? 8'd200 : 8'($urandom_range(0, 199)), i == 59);
    settle();

    // Two-pixel rows in one longer frame; the result side holds off for a
    // long stretch meanwhile so the block backs up.
    write_regs(8'd0, 8'd255, 12'd2, 12'd720);
    hold_req = 1'b1;
    for (int i = 0; i < 200; i++) send_req(8'($urandom), i == 199);
    settle();

    // Random phases with fresh register settings and idle styles.
    while (total_sent < 1580) begin
      random_config();
      send_style = $urandom_range(0, 2);
      recv_style = $urandom_range(0, 2);
      run_frames($urandom_range(60, 140));
      settle();
    end

    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
      sb.errors += sb.expected_q.size();
    end
    $display("Covered %0d pixel requests (%0d random) over %0d frames, %0d window matches,",
             total_sent, random_sent, sb.centroids, sb.match_total);
    $display("  %0d centroids fell back to the frame centre; %0d failures seen.",
             sb.centre_fallbacks, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
